/* sv/deq_pkg.sv */
package deq_pkg;

  // Default ring depth and fixed field widths
  localparam int DEPTH_DEF = 1024;
  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_wr;
    logic mem_rd;
    logic commit;
    logic load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic push_ok;
    logic read_ok;
  } dp_status_t;

endpackage

/* sv/deq_if.sv */
// Command channel: one beat carries one deque command
interface deq_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::CMD_W-1:0]         cmd;
  logic signed [deq_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// Response channel: one beat per command
interface deq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [deq_pkg::VALUE_W-1:0] read_value;
  logic [deq_pkg::STATUS_W-1:0]       status;
  logic [deq_pkg::OCC_W-1:0]          occupancy;
  logic                               is_empty;

  modport source (output valid, output read_value, output status, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input occupancy,
                  input is_empty, output ready);
endinterface

/* sv/deq_ctrl.sv */
module deq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  deq_pkg::dp_status_t    status,
  output deq_pkg::dp_cmd_t       cmd
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;
  logic            load_fire;

  // Output slot frees when empty or being drained this cycle
  assign load_fire = (state == deq_pkg::S_LOAD) && (!out_valid || out_ready);

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (in_valid) state_next = deq_pkg::S_EXEC;
      end
      deq_pkg::S_EXEC: begin
        state_next = deq_pkg::S_LOAD;
      end
      deq_pkg::S_LOAD: begin
        if (load_fire) state_next = deq_pkg::S_IDLE;
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      deq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      deq_pkg::S_EXEC: begin
        cmd.mem_wr = status.push_ok;
        cmd.mem_rd = status.read_ok;
        cmd.commit = 1'b1;
      end
      deq_pkg::S_LOAD: begin
        cmd.load = load_fire;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/deq_dp.sv */
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::dp_cmd_t                    cmd,
  output deq_pkg::dp_status_t                 status,
  input  logic [deq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [deq_pkg::VALUE_W-1:0]  in_value,
  output logic signed [deq_pkg::VALUE_W-1:0]  read_value,
  output logic [deq_pkg::STATUS_W-1:0]        res_status,
  output logic [deq_pkg::OCC_W-1:0]           occupancy,
  output logic                                is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Element ring
  logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [deq_pkg::VALUE_W-1:0] mem_q;

  // Pointers and fill level
  logic [AW-1:0] front;
  logic [AW-1:0] rear;
  logic [CW-1:0] count;

  // Latched command
  deq_pkg::cmd_e_t             cmd_r;
  logic [deq_pkg::VALUE_W-1:0] val_r;

  // Result held between commit and load
  deq_pkg::status_e_t res_code;
  logic               res_from_mem;

  logic          full;
  logic          empty;
  logic          is_push;
  logic          is_read;
  logic          is_pop;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] rear_inc;
  logic [AW-1:0] rear_dec;
  logic [AW-1:0] addr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Ring pointer neighbors
  assign front_inc = (front == LAST) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? LAST : front - AW'(1);
  assign rear_inc  = (rear == LAST) ? '0 : rear + AW'(1);
  assign rear_dec  = (rear == '0) ? LAST : rear - AW'(1);

  // Command decode and access address
  always_comb begin
    is_push = 1'b0;
    is_read = 1'b0;
    is_pop  = 1'b0;
    addr    = front;
    case (cmd_r)
      deq_pkg::CMD_PUSH_FRONT: begin
        is_push = 1'b1;
        addr    = front_dec;
      end
      deq_pkg::CMD_PUSH_BACK: begin
        is_push = 1'b1;
        addr    = rear;
      end
      deq_pkg::CMD_POP_FRONT: begin
        is_read = 1'b1;
        is_pop  = 1'b1;
        addr    = front;
      end
      deq_pkg::CMD_POP_BACK: begin
        is_read = 1'b1;
        is_pop  = 1'b1;
        addr    = rear_dec;
      end
      deq_pkg::CMD_PEEK_FRONT: begin
        is_read = 1'b1;
        addr    = front;
      end
      deq_pkg::CMD_PEEK_BACK: begin
        is_read = 1'b1;
        addr    = rear_dec;
      end
      default: begin
        addr = front;
      end
    endcase
  end

  assign status.push_ok = is_push && !full;
  assign status.read_ok = is_read && !empty;

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= deq_pkg::cmd_e_t'(in_cmd);
      val_r <= in_value;
    end
  end

  // Ring memory, at most one access per command
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= val_r;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[addr];
    end
  end

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      if (status.push_ok) begin
        count <= count + CW'(1);
        if (cmd_r == deq_pkg::CMD_PUSH_FRONT) front <= front_dec;
        else                                   rear  <= rear_inc;
      end else if (status.read_ok && is_pop) begin
        count <= count - CW'(1);
        if (cmd_r == deq_pkg::CMD_POP_FRONT) front <= front_inc;
        else                                  rear  <= rear_dec;
      end
    end
  end

  // Result code, decided on pre-update fill level
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_from_mem <= status.read_ok;
      if (is_push && full)       res_code <= deq_pkg::ST_FULL;
      else if (is_read && empty) res_code <= deq_pkg::ST_EMPTY;
      else                       res_code <= deq_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (res_from_mem)                       read_value <= mem_q;
      else if (res_code == deq_pkg::ST_EMPTY) read_value <= '1;
      else                                    read_value <= '0;
      res_status <= res_code;
      occupancy  <= deq_pkg::OCC_W'(count);
      is_empty   <= empty;
    end
  end

endmodule

/* sv/double_ended_queue_ring.sv */
// Double-ended queue held in a ring memory of DEPTH signed 32-bit elements.
// cmd channel: one beat per command (push front/back, pop front/back,
// peek front/back) with push_value used by the pushes.
// rsp channel: exactly one beat per command with read_value, status
// (ok, full, empty), occupancy after the command and is_empty.
// A push into a full ring is dropped with status full; a pop or peek on an
// empty ring reports status empty and read_value -1. Codes 6 and 7 do nothing.
// Sequence: a command runs through capture, one memory access with pointer
// update and load of the output register; the next command is taken only
// after the last one has been loaded. The single-port ring memory with
// registered read sets this sequence.
// When rsp stalls, the held result waits in the output register; one more
// command may be taken and run up to its load, then cmd ready stays low.
// Reset (rst, synchronous) empties the deque at once; the memory contents
// are not cleared and are never read before written.
module double_ended_queue_ring #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  deq_cmd_if.sink  cmd_ch,
  deq_rsp_if.source rsp_ch
);

  deq_pkg::dp_cmd_t    dp_cmd;
  deq_pkg::dp_status_t dp_status;

  // Sequencer
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Ring, pointers and result register
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .in_cmd     (cmd_ch.cmd),
    .in_value   (cmd_ch.push_value),
    .read_value (rsp_ch.read_value),
    .res_status (rsp_ch.status),
    .occupancy  (rsp_ch.occupancy),
    .is_empty   (rsp_ch.is_empty)
  );

`ifndef SYNTHESIS
  // Not ready again in the cycle after an accepted command
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
    else $error("command accepted on consecutive cycles");

  // Empty reads return all ones
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && (rsp_ch.status == deq_pkg::ST_EMPTY) |->
      (rsp_ch.read_value == -32'sd1) && rsp_ch.is_empty)
    else $error("empty read with wrong value or flag");

  // Rejected push reports zero and a non-empty deque
  a_full_value: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && (rsp_ch.status == deq_pkg::ST_FULL) |->
      (rsp_ch.read_value == 32'sd0) && !rsp_ch.is_empty)
    else $error("full push with wrong value or flag");

  // Empty flag agrees with occupancy while the count fits its field
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && (DEPTH < 2048) |-> (rsp_ch.is_empty == (rsp_ch.occupancy == '0)))
    else $error("is_empty disagrees with occupancy");
`endif

endmodule

/* sim/deq_score_pkg.sv */
`timescale 1ns / 100ps

package deq_score_pkg;
  import deq_pkg::*;

  // One expected response beat
  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
  } deque_rsp_t;

  class deque_mirror;
    logic signed [VALUE_W-1:0] ring [DEPTH_DEF];
    int unsigned front;
    int unsigned rear;
    int unsigned count;
    deque_rsp_t  pending_rsp[$];
    int          mismatches;

    function new();
      front      = 0;
      rear       = 0;
      count      = 0;
      mismatches = 0;
    endfunction

    function int unsigned ring_prev(int unsigned idx);
      return (idx == 0) ? DEPTH_DEF - 1 : idx - 1;
    endfunction

    function int unsigned ring_next(int unsigned idx);
      return (idx == DEPTH_DEF - 1) ? 0 : idx + 1;
    endfunction

    // Update the mirrored deque for an accepted command beat and queue its response
    function void apply_cmd(logic [CMD_W-1:0] code, logic signed [VALUE_W-1:0] value);
      deque_rsp_t r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (code)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            if (code == CMD_PUSH_FRONT) begin
              front       = ring_prev(front);
              ring[front] = value;
            end else begin
              ring[rear] = value;
              rear       = ring_next(rear);
            end
            count++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
          if (count == 0) begin
            r.status     = ST_EMPTY;
            r.read_value = -1;
          end else begin
            case (code)
              CMD_POP_FRONT: begin
                r.read_value = ring[front];
                front        = ring_next(front);
                count--;
              end
              CMD_POP_BACK: begin
                rear         = ring_prev(rear);
                r.read_value = ring[rear];
                count--;
              end
              CMD_PEEK_FRONT: r.read_value = ring[front];
              default:        r.read_value = ring[ring_prev(rear)];
            endcase
          end
        end
        // spare codes leave the deque untouched
        default: ;
      endcase
      r.occupancy = OCC_W'(count);
      r.is_empty  = (count == 0);
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Compare a response beat against the oldest pending expectation
    task check_rsp(logic signed [VALUE_W-1:0] read_value, logic [STATUS_W-1:0] status,
                   logic [OCC_W-1:0] occupancy, logic is_empty);
      deque_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with no command pending");
        return;
      end
      exp_rsp = pending_rsp[0];
      pending_rsp.delete(0);
      if (read_value !== exp_rsp.read_value)
        report_mismatch($sformatf("read_value got %0d expected %0d",
                                  read_value, exp_rsp.read_value));
      if (status !== exp_rsp.status)
        report_mismatch($sformatf("status got %0d expected %0d", status, exp_rsp.status));
      if (occupancy !== exp_rsp.occupancy)
        report_mismatch($sformatf("occupancy got %0d expected %0d",
                                  occupancy, exp_rsp.occupancy));
      if (is_empty !== exp_rsp.is_empty)
        report_mismatch($sformatf("is_empty got %0b expected %0b", is_empty, exp_rsp.is_empty));
    endtask
  endclass

endpackage

/* sim/tb_double_ended_queue_ring.sv */
`timescale 1ns / 100ps

module tb_double_ended_queue_ring;
  import deq_pkg::*;
  import deq_score_pkg::*;

  // Codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;      // no idling on either side when set
  bit   hold_off = 1'b0;  // request for one long response stall

  deque_mirror mirror;

  deq_cmd_if cmd_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue_ring i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .rsp_ch (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one command beat, with an occasional idle burst first
  task automatic send_cmd(logic [CMD_W-1:0] code, logic signed [VALUE_W-1:0] value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= code;
    cmd_ch.push_value <= value;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    mirror.apply_cmd(code, value);
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return -1;
      3:       return 0;
      default: return $urandom();
    endcase
  endfunction

  // Weighted command choice; whatever is left over goes to the spare codes
  function automatic logic [CMD_W-1:0] pick_code(int push_pct, int pop_pct, int peek_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (r < push_pct + pop_pct + peek_pct)
      return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
    return $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
  endfunction

  task automatic run_mix(int n, int push_pct, int pop_pct, int peek_pct, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_off = 1'b1;
      send_cmd(pick_code(push_pct, pop_pct, peek_pct), rand_value());
    end
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin : rsp_side
    int gap;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 10);
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
        if (rsp_ch.valid && rsp_ch.ready)
          mirror.check_rsp(rsp_ch.read_value, rsp_ch.status, rsp_ch.occupancy,
                           rsp_ch.is_empty);
      end
    end
  end

  // Command side and end of run
  initial begin : cmd_side
    mirror = new();
    cmd_ch.valid      <= 1'b0;
    cmd_ch.cmd        <= CMD_PUSH_FRONT;
    cmd_ch.push_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reads on the empty deque and spare codes
    send_cmd(CMD_PEEK_FRONT, 0);
    send_cmd(CMD_PEEK_BACK, 0);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
    send_cmd(CMD_SPARE_A, VAL_MAX);
    send_cmd(CMD_SPARE_B, VAL_MIN);
    // value extremes through both ends
    send_cmd(CMD_PUSH_BACK, VAL_MAX);
    send_cmd(CMD_PUSH_FRONT, VAL_MIN);
    send_cmd(CMD_PUSH_BACK, -1);
    send_cmd(CMD_PUSH_FRONT, 0);
    send_cmd(CMD_PEEK_FRONT, 0);
    send_cmd(CMD_PEEK_BACK, 0);
    send_cmd(CMD_SPARE_B, -1);
    send_cmd(CMD_POP_BACK, 0);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_PUSH_FRONT, 32'sh5A5A_A5A5);
    send_cmd(CMD_POP_BACK, 0);

    // balanced traffic, with the long response hold-off early on
    run_mix(150, 40, 30, 25, 20);

    // fill to the top, then push into the full ring
    while (mirror.count < DEPTH_DEF)
      send_cmd(pick_code(94, 0, 4), rand_value());
    run_mix(12, 80, 0, 20, -1);

    // closing stretch at full rate, leaning on pops
    calm = 1'b1;
    run_mix(550, 20, 65, 15, -1);
    cmd_ch.valid <= 1'b0;

    while (mirror.pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.pending_rsp.size() != 0)
      mirror.report_mismatch("expected responses left over");
    if (mirror.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
